>>> hw/rtl/config_frame_receiver_crc16_assert.svh
// Assertion macros for the configuration frame receiver checker.
// Depends on clk and rst_n being visible in the scope of use.
`ifndef CONFIG_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define CONFIG_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define CFRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define CFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cfrc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame receiver.
// No dependencies.
`default_nettype none

package cfrc_pkg;

    localparam int EXPECTED_PAYLOAD = 800;
    localparam int MAX_FRAME        = 1024;
    localparam int LEN_LIMIT_RAW    = MAX_FRAME - 9;
    localparam int LEN_LIMIT        = (LEN_LIMIT_RAW < 0) ? 0 :
                                      (LEN_LIMIT_RAW > 1023) ? 1023 : LEN_LIMIT_RAW;

    localparam logic [7:0]  HDR_BYTE0  = 8'h5A;
    localparam logic [7:0]  HDR_BYTE1  = 8'hA5;
    localparam logic [7:0]  TRL_BYTE0  = 8'hED;
    localparam logic [7:0]  TRL_BYTE1  = 8'hDE;
    localparam logic [7:0]  CMD_READ   = 8'h01;
    localparam logic [7:0]  CMD_WRITE  = 8'h02;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [1:0]  KIND_NONE  = 2'd0;
    localparam logic [1:0]  KIND_READ  = 2'd1;
    localparam logic [1:0]  KIND_WRITE = 2'd2;

    typedef enum logic [3:0] {
        PH_HUNT0   = 4'd0,
        PH_HUNT1   = 4'd1,
        PH_CMD     = 4'd2,
        PH_LENLO   = 4'd3,
        PH_LENHI   = 4'd4,
        PH_SKIP    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRCLO   = 4'd7,
        PH_CRCHI   = 4'd8,
        PH_TRL0    = 4'd9,
        PH_TRL1    = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_READ   = 3'd1,
        EV_WOK    = 3'd2,
        EV_BADCRC = 3'd3,
        EV_BADLEN = 3'd4,
        EV_DROP   = 3'd5
    } frame_event_t;

    typedef struct packed {
        logic         payload_valid;
        logic [7:0]   payload_byte;
        logic [9:0]   payload_index;
        frame_event_t frame_event;
    } result_t;

    // Reflected CRC-16 update, one byte, eight shift steps.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfrc_channels.sv
// Valid/ready channel interfaces for received bytes and result beats.
// Depends on nothing; payload widths follow the frame receiver fields.
`default_nettype none

interface cfrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfrc_result_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [9:0] payload_index;
    logic [2:0] frame_event;

    modport source (output valid, output payload_valid, output payload_byte,
                    output payload_index, output frame_event, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input payload_index, input frame_event, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cfrc_frame_fsm.sv
// Frame parser: header hunt, command/length decode, payload CRC and trailer check.
// Depends on cfrc_pkg for phase codes, event codes and the CRC update.
`default_nettype none

module cfrc_frame_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    output cfrc_pkg::result_t    result
);

    cfrc_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       command_kind_reg, command_kind_next;
    logic [9:0]       payload_length_reg, payload_length_next;
    logic [9:0]       byte_count_reg, byte_count_next;
    logic [15:0]      running_crc_reg, running_crc_next;
    logic [15:0]      received_crc_reg, received_crc_next;

    logic [9:0]       count_inc;
    logic [15:0]      len_word;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg          <= cfrc_pkg::PH_HUNT0;
            command_kind_reg   <= cfrc_pkg::KIND_NONE;
            payload_length_reg <= '0;
            byte_count_reg     <= '0;
            running_crc_reg    <= cfrc_pkg::CRC_INIT;
            received_crc_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            command_kind_reg   <= command_kind_next;
            payload_length_reg <= payload_length_next;
            byte_count_reg     <= byte_count_next;
            running_crc_reg    <= running_crc_next;
            received_crc_reg   <= received_crc_next;
        end
    end

    assign count_inc = byte_count_reg + 10'd1;
    assign len_word  = {rx_byte, received_crc_reg[7:0]};

    always_comb begin
        phase_next          = phase_reg;
        command_kind_next   = command_kind_reg;
        payload_length_next = payload_length_reg;
        byte_count_next     = byte_count_reg;
        running_crc_next    = running_crc_reg;
        received_crc_next   = received_crc_reg;
        result              = '0;
        result.frame_event  = cfrc_pkg::EV_NONE;

        unique case (phase_reg)
            cfrc_pkg::PH_HUNT1:
            begin
                if (rx_byte == cfrc_pkg::HDR_BYTE1)
                    phase_next = cfrc_pkg::PH_CMD;
                else if (rx_byte == cfrc_pkg::HDR_BYTE0)
                    phase_next = cfrc_pkg::PH_HUNT1;
                else
                    phase_next = cfrc_pkg::PH_HUNT0;
            end
            cfrc_pkg::PH_CMD:
            begin
                if (rx_byte == cfrc_pkg::CMD_READ)
                begin
                    command_kind_next = cfrc_pkg::KIND_READ;
                    phase_next        = cfrc_pkg::PH_LENLO;
                end
                else if (rx_byte == cfrc_pkg::CMD_WRITE)
                begin
                    command_kind_next = cfrc_pkg::KIND_WRITE;
                    phase_next        = cfrc_pkg::PH_LENLO;
                end
                else
                begin
                    result.frame_event = cfrc_pkg::EV_DROP;
                    phase_next         = cfrc_pkg::PH_HUNT0;
                end
            end
            cfrc_pkg::PH_LENLO:
            begin
                // park the low length byte until the high byte arrives
                received_crc_next = {8'h00, rx_byte};
                phase_next        = cfrc_pkg::PH_LENHI;
            end
            cfrc_pkg::PH_LENHI:
            begin
                received_crc_next = '0;
                byte_count_next   = '0;
                running_crc_next  = cfrc_pkg::CRC_INIT;
                if (command_kind_reg == cfrc_pkg::KIND_READ)
                begin
                    payload_length_next = '0;
                    phase_next          = cfrc_pkg::PH_SKIP;
                end
                else if (len_word > 16'(cfrc_pkg::LEN_LIMIT))
                begin
                    payload_length_next = '0;
                    result.frame_event  = cfrc_pkg::EV_DROP;
                    phase_next          = cfrc_pkg::PH_HUNT0;
                end
                else
                begin
                    payload_length_next = len_word[9:0];
                    phase_next = (len_word == 16'd0) ? cfrc_pkg::PH_CRCLO
                                                     : cfrc_pkg::PH_PAYLOAD;
                end
            end
            cfrc_pkg::PH_SKIP:
            begin
                byte_count_next = count_inc;
                if (count_inc >= 10'd2)
                    phase_next = cfrc_pkg::PH_TRL0;
            end
            cfrc_pkg::PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = byte_count_reg;
                running_crc_next     = cfrc_pkg::crc16_update(running_crc_reg, rx_byte);
                byte_count_next      = count_inc;
                if (count_inc >= payload_length_reg)
                    phase_next = cfrc_pkg::PH_CRCLO;
            end
            cfrc_pkg::PH_CRCLO:
            begin
                received_crc_next = {8'h00, rx_byte};
                phase_next        = cfrc_pkg::PH_CRCHI;
            end
            cfrc_pkg::PH_CRCHI:
            begin
                received_crc_next = {rx_byte, received_crc_reg[7:0]};
                phase_next        = cfrc_pkg::PH_TRL0;
            end
            cfrc_pkg::PH_TRL0:
            begin
                if (rx_byte == cfrc_pkg::TRL_BYTE0)
                    phase_next = cfrc_pkg::PH_TRL1;
                else
                begin
                    result.frame_event = cfrc_pkg::EV_DROP;
                    phase_next         = cfrc_pkg::PH_HUNT0;
                end
            end
            cfrc_pkg::PH_TRL1:
            begin
                if (rx_byte != cfrc_pkg::TRL_BYTE1)
                    result.frame_event = cfrc_pkg::EV_DROP;
                else if (command_kind_reg == cfrc_pkg::KIND_READ)
                    result.frame_event = cfrc_pkg::EV_READ;
                else if (payload_length_reg != 10'(cfrc_pkg::EXPECTED_PAYLOAD))
                    result.frame_event = cfrc_pkg::EV_BADLEN;
                else if (running_crc_reg != received_crc_reg)
                    result.frame_event = cfrc_pkg::EV_BADCRC;
                else
                    result.frame_event = cfrc_pkg::EV_WOK;
                phase_next = cfrc_pkg::PH_HUNT0;
            end
            default:
            begin
                // first header byte hunt, also taken by unused phase codes
                phase_next = (rx_byte == cfrc_pkg::HDR_BYTE0) ? cfrc_pkg::PH_HUNT1
                                                             : cfrc_pkg::PH_HUNT0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/config_frame_receiver_crc16.sv
// Channel    | Dir  | Beat fields
// link       | sink | rx_byte[7:0]
// result     | src  | payload_valid, payload_byte[7:0], payload_index[9:0], frame_event[2:0]
//
// One byte in, one result beat out; a byte is taken every cycle while the output
// register is empty or being drained, so throughput is one beat per clock.
// Each result beat is decoded combinationally from the accepted byte and the parser
// state and held in the output register, valid in the cycle after the byte is taken.
// A stalled result holds the output register and blocks link.ready until taken.
// rst_n clears the parser to header hunt and empties the output register.
// Depends on cfrc_pkg, cfrc_channels and cfrc_frame_fsm.
`default_nettype none

module config_frame_receiver_crc16 (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cfrc_byte_if.sink      link,
    cfrc_result_if.source  result
);

    cfrc_pkg::result_t fsm_result;
    cfrc_pkg::result_t res_reg;
    logic              res_valid_reg;
    logic              step;

    assign link.ready = !res_valid_reg || result.ready;
    assign step       = link.valid && link.ready;

    cfrc_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (link.rx_byte),
        .result  (fsm_result)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // hold the beat while stalled
    always_ff @(posedge clk) begin
        if (step)
            res_reg <= fsm_result;
    end

    assign result.valid         = res_valid_reg;
    assign result.payload_valid = res_reg.payload_valid;
    assign result.payload_byte  = res_reg.payload_byte;
    assign result.payload_index = res_reg.payload_index;
    assign result.frame_event   = res_reg.frame_event;

endmodule

`default_nettype wire

>>> hw/rtl/cfrc_checker.sv
// Port-level checks for the configuration frame receiver, bound to its top level.
// Depends on cfrc_pkg and config_frame_receiver_crc16_assert.svh.
`default_nettype none
`include "config_frame_receiver_crc16_assert.svh"

module cfrc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       link_valid,
    input wire logic       link_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       payload_valid,
    input wire logic [7:0] payload_byte,
    input wire logic [9:0] payload_index,
    input wire logic [2:0] frame_event
);

    `CFRC_ASSERT_NOW(a_payload_no_event, res_valid && payload_valid, frame_event == cfrc_pkg::EV_NONE, "payload beat carries a frame event")
    `CFRC_ASSERT_NOW(a_idle_fields_zero, res_valid && !payload_valid, payload_byte == 8'h00 && payload_index == 10'd0, "non-payload beat has nonzero payload fields")
    `CFRC_ASSERT_NOW(a_stall_blocks_link, res_valid && !res_ready, !link_ready, "byte taken while result is stalled")
    `CFRC_ASSERT_NEXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(payload_valid) && $stable(payload_byte) && $stable(payload_index) && $stable(frame_event), "stalled result beat changed")
    `CFRC_ASSERT_NEXT(a_beat_gives_result, link_valid && link_ready, res_valid, "accepted byte produced no result beat")

endmodule

bind config_frame_receiver_crc16 cfrc_checker u_cfrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .link_valid    (link.valid),
    .link_ready    (link.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .payload_valid (result.payload_valid),
    .payload_byte  (result.payload_byte),
    .payload_index (result.payload_index),
    .frame_event   (result.frame_event)
);

`default_nettype wire

>>> tb/tb_config_frame_receiver_crc16.sv
`timescale 1ns / 100ps
// Self-checking testbench for config_frame_receiver_crc16: random and directed link bytes,
// a frame parser model that predicts every result beat, random stalls on both channels.
// Depends on cfrc_pkg, cfrc_channels and the receiver RTL.

module tb_config_frame_receiver_crc16;

    import cfrc_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int FRAME_ITEMS   = 1500;
    localparam int RANDOM_MIN    = 200;
    localparam int CALM_WINDOW   = 600;
    localparam int CALM_PERIOD   = 4096;
    localparam int IDLE_PERCENT  = 31;
    localparam int DRAIN_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    cfrc_byte_if   link_if ();
    cfrc_result_if result_if ();

    config_frame_receiver_crc16 u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .link   (link_if),
        .result (result_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [7:0]  link_bytes[$];
    result_t     expected_beats[$];
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned quiet_cycles = 0;

    // Parser state of the frame model, at reset values.
    phase_t      rx_phase      = PH_HUNT0;
    logic [1:0]  cmd_kind      = KIND_NONE;
    logic [9:0]  frame_len     = '0;
    logic [9:0]  bytes_seen    = '0;
    logic [15:0] payload_crc   = CRC_INIT;
    logic [15:0] held_word     = '0;
    result_t     predicted;

    // CRC-16/MODBUS, one bit at a time, LSB first.
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic decode_link_byte(input logic [7:0] b, output result_t r);
        logic [15:0] len;
        r = '0;
        r.frame_event = EV_NONE;
        case (rx_phase)
            PH_HUNT1:
                rx_phase = (b == HDR_BYTE1) ? PH_CMD :
                           (b == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
            PH_CMD:
                if (b == CMD_READ)
                begin
                    cmd_kind = KIND_READ;
                    rx_phase = PH_LENLO;
                end
                else if (b == CMD_WRITE)
                begin
                    cmd_kind = KIND_WRITE;
                    rx_phase = PH_LENLO;
                end
                else
                begin
                    r.frame_event = EV_DROP;
                    rx_phase = PH_HUNT0;
                end
            PH_LENLO:
            begin
                held_word = {8'h00, b};
                rx_phase  = PH_LENHI;
            end
            PH_LENHI:
            begin
                len         = {b, held_word[7:0]};
                held_word   = '0;
                bytes_seen  = '0;
                payload_crc = CRC_INIT;
                if (cmd_kind == KIND_READ)
                begin
                    frame_len = '0;
                    rx_phase  = PH_SKIP;
                end
                else if (len > LEN_LIMIT)
                begin
                    frame_len = '0;
                    r.frame_event = EV_DROP;
                    rx_phase  = PH_HUNT0;
                end
                else
                begin
                    frame_len = len[9:0];
                    rx_phase  = (len == 0) ? PH_CRCLO : PH_PAYLOAD;
                end
            end
            PH_SKIP:
            begin
                bytes_seen = bytes_seen + 10'd1;
                if (bytes_seen >= 10'd2)
                    rx_phase = PH_TRL0;
            end
            PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = bytes_seen;
                payload_crc = modbus_crc_step(payload_crc, b);
                bytes_seen  = bytes_seen + 10'd1;
                if (bytes_seen >= frame_len)
                    rx_phase = PH_CRCLO;
            end
            PH_CRCLO:
            begin
                held_word = {8'h00, b};
                rx_phase  = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                held_word[15:8] = b;
                rx_phase = PH_TRL0;
            end
            PH_TRL0:
                if (b == TRL_BYTE0)
                    rx_phase = PH_TRL1;
                else
                begin
                    r.frame_event = EV_DROP;
                    rx_phase = PH_HUNT0;
                end
            PH_TRL1:
            begin
                if (b != TRL_BYTE1)
                    r.frame_event = EV_DROP;
                else if (cmd_kind == KIND_READ)
                    r.frame_event = EV_READ;
                else if (frame_len != 10'(EXPECTED_PAYLOAD))
                    r.frame_event = EV_BADLEN;
                else if (payload_crc != held_word)
                    r.frame_event = EV_BADCRC;
                else
                    r.frame_event = EV_WOK;
                rx_phase = PH_HUNT0;
            end
            default:
                rx_phase = (b == HDR_BYTE0) ? PH_HUNT1 : PH_HUNT0;
        endcase
    endtask

    // Build one frame; sent below len truncates the payload and ends the frame there.
    task automatic push_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input int unsigned sent, input bit bad_crc, input bit bad_trl);
        logic [15:0] crc;
        logic [7:0]  d;
        logic [7:0]  t0;
        logic [7:0]  t1;
        crc = CRC_INIT;
        t0  = TRL_BYTE0;
        t1  = TRL_BYTE1;
        link_bytes.push_back(HDR_BYTE0);
        link_bytes.push_back(HDR_BYTE1);
        link_bytes.push_back(cmd);
        if (cmd != CMD_READ && cmd != CMD_WRITE)
            return;
        link_bytes.push_back(len[7:0]);
        link_bytes.push_back(len[15:8]);
        if (cmd == CMD_WRITE && len > LEN_LIMIT)
            return;
        if (cmd == CMD_READ)
        begin
            link_bytes.push_back(8'($urandom));
            link_bytes.push_back(8'($urandom));
        end
        else
        begin
            for (int i = 0; i < sent; i++)
            begin
                d   = 8'($urandom);
                crc = modbus_crc_step(crc, d);
                link_bytes.push_back(d);
            end
            if (sent < len)
                return;
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
            link_bytes.push_back(crc[7:0]);
            link_bytes.push_back(crc[15:8]);
        end
        if (bad_trl)
        begin
            if ($urandom_range(0, 1))
                t0 = t0 ^ 8'($urandom_range(1, 255));
            else
                t1 = t1 ^ 8'($urandom_range(1, 255));
        end
        link_bytes.push_back(t0);
        link_bytes.push_back(t1);
    endtask

    task automatic build_stimulus();
        int unsigned random_start;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  cmd;
        // Resync on a repeated first header byte, then an unknown command.
        link_bytes.push_back(8'hFF);
        push_frame(8'h00, 16'd0, 0, 1'b0, 1'b0);
        link_bytes.push_back(HDR_BYTE0);
        push_frame(8'hFF, 16'd0, 0, 1'b0, 1'b0);
        // Length one past the limit, zero length, then read requests, the second with a bad trailer.
        push_frame(CMD_WRITE, 16'(LEN_LIMIT + 1), 0, 1'b0, 1'b0);
        push_frame(CMD_WRITE, 16'd0, 0, 1'b0, 1'b0);
        push_frame(CMD_READ, 16'h1234, 0, 1'b0, 1'b0);
        push_frame(CMD_READ, 16'hFFFF, 0, 1'b0, 1'b1);

        // Full-size frames: good CRC, then bad CRC.
        push_frame(CMD_WRITE, 16'(EXPECTED_PAYLOAD), EXPECTED_PAYLOAD, 1'b0, 1'b0);
        push_frame(CMD_WRITE, 16'(EXPECTED_PAYLOAD), EXPECTED_PAYLOAD, 1'b1, 1'b0);

        // Top up to the target, always adding some random traffic.
        random_start = link_bytes.size();
        while (link_bytes.size() < FRAME_ITEMS ||
               link_bytes.size() - random_start < RANDOM_MIN)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = $urandom_range(0, 24);
                push_frame(CMD_WRITE, 16'(len), len, $urandom_range(0, 3) == 0,
                           $urandom_range(0, 7) == 0);
            end
            else if (pick < 63)
                push_frame(CMD_READ, 16'($urandom), 0, 1'b0, $urandom_range(0, 7) == 0);
            else if (pick < 73)
            begin
                repeat ($urandom_range(1, 8))
                    link_bytes.push_back(8'($urandom));
            end
            else if (pick < 80)
            begin
                cmd = 8'($urandom);
                if (cmd == CMD_READ || cmd == CMD_WRITE)
                    cmd = cmd ^ 8'h80;
                push_frame(cmd, 16'd0, 0, 1'b0, 1'b0);
            end
            else if (pick < 86)
                push_frame(CMD_WRITE, 16'($urandom_range(LEN_LIMIT + 1, 16'hFFFF)), 0,
                           1'b0, 1'b0);
            else if (pick < 93)
            begin
                len = $urandom_range(1, 24);
                push_frame(CMD_WRITE, 16'(len), $urandom_range(0, len - 1), 1'b0, 1'b0);
            end
            else
            begin
                len = $urandom_range(25, 200);
                push_frame(CMD_WRITE, 16'(len), len, $urandom_range(0, 1), 1'b0);
            end
        end
    endtask

    // Random idling, except in a calm window of each period.
    function automatic bit pause_now();
        return (cycle_count % CALM_PERIOD >= CALM_WINDOW) &&
               ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        link_if.valid   = 1'b0;
        link_if.rx_byte = '0;
        result_if.ready = 1'b0;
    end

    // Link driver: predict on each accepted beat, then present the next byte or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_if.valid   <= 1'b0;
            link_if.rx_byte <= '0;
        end
        else
        begin
            if (link_if.valid && link_if.ready)
            begin
                decode_link_byte(link_if.rx_byte, predicted);
                expected_beats.push_back(predicted);
            end
            if (!link_if.valid || link_if.ready)
            begin
                if (link_bytes.size() != 0 && !pause_now())
                begin
                    link_if.valid   <= 1'b1;
                    link_if.rx_byte <= link_bytes.pop_front();
                end
                else
                    link_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, event %0d", $time,
                             result_if.frame_event);
                end
                else
                begin
                    predicted = expected_beats.pop_front();
                    check_field("payload_valid", 10'(predicted.payload_valid),
                                10'(result_if.payload_valid));
                    check_field("payload_byte", 10'(predicted.payload_byte),
                                10'(result_if.payload_byte));
                    check_field("payload_index", predicted.payload_index,
                                result_if.payload_index);
                    check_field("frame_event", 10'(predicted.frame_event),
                                10'(result_if.frame_event));
                end
            end
            result_if.ready <= !pause_now();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n || (link_if.valid && link_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (link_bytes.size() != 0 || link_if.valid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
